FILE: hw/rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types and constants for the ground region corner projector.
// ----------------------------------------------------------------------------
package grc_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_ROW0_A   = 3'd0;
  localparam logic [2:0] REG_ROW0_B   = 3'd1;
  localparam logic [2:0] REG_ROW1_A   = 3'd2;
  localparam logic [2:0] REG_ROW1_B   = 3'd3;
  localparam logic [2:0] REG_ROW2_A   = 3'd4;
  localparam logic [2:0] REG_ROW2_B   = 3'd5;
  localparam logic [2:0] REG_CAM_H    = 3'd6;
  localparam logic [2:0] REG_FRAME_RS = 3'd7;

  // Pipeline depths of the lanes (cycles from input to registered output)
  localparam int DEPTH_LAT  = 64;
  localparam int CORNER_LAT = 23;

  localparam logic signed [15:0] FAIL_PIX = -16'sd10000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ROWS_BAD  = 2'd1,
    ST_DEPTH_BAD = 2'd2,
    ST_PROJ_FAIL = 2'd3
  } status_t;

  // 3x4 projection matrix, signed Q.F entries, [row][col]
  typedef logic [2:0][3:0][31:0] mat_t;

  // Depth lane result
  typedef struct packed {
    logic        bad;
    logic        zneg;
    logic [60:0] zmag;
  } depth_t;

endpackage

FILE: hw/rtl/grc_if.sv
// ----------------------------------------------------------------------------
// grc_if
// Valid/ready channels of the ground region corner projector.
// ----------------------------------------------------------------------------
interface grc_item_if;
  logic        valid;
  logic        ready;
  logic [11:0] row_top;
  logic [11:0] row_bottom;
  logic [22:0] width_top;
  logic [22:0] width_bottom;

  modport source (output valid, row_top, row_bottom, width_top, width_bottom, input ready);
  modport sink (input valid, row_top, row_bottom, width_top, width_bottom, output ready);
endinterface

interface grc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] bottom_left_x;
  logic signed [15:0] bottom_left_y;
  logic signed [15:0] bottom_right_x;
  logic signed [15:0] bottom_right_y;
  logic signed [15:0] top_right_x;
  logic signed [15:0] top_right_y;
  logic signed [15:0] top_left_x;
  logic signed [15:0] top_left_y;
  logic [1:0]         status;

  modport source (output valid, bottom_left_x, bottom_left_y, bottom_right_x,
                  bottom_right_y, top_right_x, top_right_y, top_left_x, top_left_y,
                  status, input ready);
  modport sink (input valid, bottom_left_x, bottom_left_y, bottom_right_x,
                bottom_right_y, top_right_x, top_right_y, top_left_x, top_left_y,
                status, output ready);
endinterface

FILE: hw/rtl/grc_div_pipe.sv
// ----------------------------------------------------------------------------
// grc_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// (quotient would need more than QB bits) and a sideband carried alongside.
// ----------------------------------------------------------------------------
module grc_div_pipe #(
  parameter int NW = 66,
  parameter int DW = 44,
  parameter int QB = 60,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic [QB-1:0] quo,
  output logic [DW-1:0] rem,
  output logic          over,
  output logic [SW-1:0] side_q
);

  localparam int CW = DW + QB + 1;

  logic [NW-1:0] r_st [QB+1];
  logic [QB-1:0] q_st [QB+1];
  logic [DW-1:0] d_st [QB+1];
  logic          o_st [QB+1];
  logic [SW-1:0] s_st [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      r_st[0] <= num;
      q_st[0] <= '0;
      d_st[0] <= den;
      o_st[0] <= CW'(num >> QB) >= CW'(den);
      s_st[0] <= side;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [CW-1:0] rx;
    logic [CW-1:0] dx;
    logic          ge;

    assign rx = CW'(r_st[k-1]);
    assign dx = CW'(d_st[k-1]) << (QB - k);
    assign ge = rx >= dx;

    always_ff @(posedge clk) begin
      if (en) begin
        r_st[k] <= ge ? NW'(rx - dx) : r_st[k-1];
        q_st[k] <= (q_st[k-1] << 1) | QB'(ge);
        d_st[k] <= d_st[k-1];
        o_st[k] <= o_st[k-1];
        s_st[k] <= s_st[k-1];
      end
    end
  end

  assign quo    = q_st[QB];
  assign rem    = DW'(r_st[QB]);
  assign over   = o_st[QB];
  assign side_q = s_st[QB];

endmodule

FILE: hw/rtl/grc_depth_lane.sv
// ----------------------------------------------------------------------------
// grc_depth_lane
// Ground depth for one image row: Z = ((v*m21-m11)*H + v*m23-m13)/(m12-v*m22).
// ----------------------------------------------------------------------------
module grc_depth_lane
  import grc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        en,
  input  logic [11:0] row,
  input  mat_t        mat,
  input  logic [20:0] h,
  output depth_t      dep
);

  localparam int NMW     = 66;
  localparam int DVW     = NMW + FRAC_BITS;
  localparam int DEN_EPS = (1 << FRAC_BITS) / 1000000000;

  // stage 1: integer row products
  logic signed [12:0] vs;
  logic signed [44:0] den_c, a_c, b_c;
  logic signed [44:0] den1, a1, b1;

  assign vs    = $signed({1'b0, row});
  assign den_c = $signed(mat[1][2]) - vs * $signed(mat[2][2]);
  assign a_c   = vs * $signed(mat[2][1]) - $signed(mat[1][1]);
  assign b_c   = vs * $signed(mat[2][3]) - $signed(mat[1][3]);

  always_ff @(posedge clk) begin
    if (en) begin
      den1 <= den_c;
      a1   <= a_c;
      b1   <= b_c;
    end
  end

  // stage 2: |a| * H
  logic [43:0]        amag;
  logic [64:0]        prod2;
  logic               aneg2;
  logic signed [44:0] b2, den2;

  assign amag = 44'(a1[44] ? -a1 : a1);

  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= 65'(amag) * 65'(h);
      aneg2 <= a1[44];
      b2    <= b1;
      den2  <= den1;
    end
  end

  // stage 3: numerator, magnitudes, divider operands
  logic signed [66:0] tn, bx, num;
  logic [NMW-1:0]     nmag;
  logic [43:0]        dmag;
  logic               bad;
  logic [DVW-1:0]     dv3;
  logic [43:0]        dd3;
  logic [1:0]         sd3;

  assign tn   = $signed({2'b00, 65'(prod2 >> FRAC_BITS)});
  assign bx   = 67'(b2);
  assign num  = aneg2 ? bx - tn : bx + tn;
  assign nmag = NMW'(num[66] ? -num : num);
  assign dmag = 44'(den2[44] ? -den2 : den2);
  assign bad  = dmag <= 44'(DEN_EPS);

  always_ff @(posedge clk) begin
    if (en) begin
      dv3 <= DVW'(nmag) << FRAC_BITS;
      dd3 <= bad ? 44'd1 : dmag;
      sd3 <= {num[66] ^ den2[44], bad};
    end
  end

  logic [59:0] quo;
  logic [43:0] rem_unused;
  logic        over;
  logic [1:0]  sdq;

  grc_div_pipe #(.NW(DVW), .DW(44), .QB(60), .SW(2)) u_div (
    .clk    (clk),
    .en     (en),
    .num    (dv3),
    .den    (dd3),
    .side   (sd3),
    .quo    (quo),
    .rem    (rem_unused),
    .over   (over),
    .side_q (sdq)
  );

  assign dep.bad  = sdq[0];
  assign dep.zneg = sdq[1];
  assign dep.zmag = over ? (61'(1) << 60) : {1'b0, quo};

endmodule

FILE: hw/rtl/grc_corner_lane.sv
// ----------------------------------------------------------------------------
// grc_corner_lane
// Projects one trapezoid corner (X = +-W/2, Y = H, Z) and rounds u/w, v/w
// to a saturated pixel.
// ----------------------------------------------------------------------------
module grc_corner_lane
  import grc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  mat_t               mat,
  input  logic [20:0]        h,
  input  logic [21:0]        hw,
  input  logic               xneg,
  input  depth_t             dep,
  output logic signed [15:0] px,
  output logic signed [15:0] py,
  output logic               fail
);

  localparam int W_EPS = (1 << FRAC_BITS) / 1000000;
  localparam logic [92:0] SAT93 = 93'(1) << 60;
  localparam logic signed [62:0] SATP = 63'sd1 <<< 60;

  function automatic logic [31:0] abs32(logic [31:0] x);
    return x[31] ? 32'(-x) : x;
  endfunction

  function automatic logic signed [61:0] clamp_s(logic signed [62:0] x);
    logic signed [62:0] y;
    y = x;
    if (x > SATP) y = SATP;
    if (x < -SATP) y = -SATP;
    return 62'(y);
  endfunction

  function automatic logic signed [15:0] round_pix(logic [16:0] q, logic [60:0] r,
                                                   logic [60:0] b, logic over, logic neg);
    logic [61:0] rr;
    logic [61:0] bb;
    logic        up;
    logic [17:0] q1;
    logic signed [15:0] res;
    rr  = {r, 1'b0};
    bb  = {1'b0, b};
    up  = (rr > bb) || ((rr == bb) && q[0]);
    q1  = 18'(q) + 18'(up);
    if (neg) begin
      res = (over || q1 > 18'd32768) ? -16'sd32768 : 16'(-q1);
    end else begin
      res = (over || q1 > 18'd32767) ? 16'sd32767 : 16'(q1);
    end
    return res;
  endfunction

  // C1: partial products
  logic [53:0] p0 [3];
  logic [52:0] p1 [3];
  logic [63:0] pl [3];
  logic [60:0] ph [3];
  logic        s0 [3];
  logic        s1 [3];
  logic        s2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        p0[r] <= 54'(abs32(mat[r][0])) * 54'(hw);
        p1[r] <= 53'(abs32(mat[r][1])) * 53'(h);
        pl[r] <= 64'(abs32(mat[r][2])) * 64'(dep.zmag[31:0]);
        ph[r] <= 61'(abs32(mat[r][2])) * 61'(dep.zmag[60:32]);
        s0[r] <= mat[r][0][31] ^ xneg;
        s1[r] <= mat[r][1][31];
        s2[r] <= mat[r][2][31] ^ dep.zneg;
      end
    end
  end

  // C2: scale, saturate, first sum
  logic signed [56:0] sum01_c [3];
  logic signed [61:0] q2_c [3];
  logic signed [56:0] sum01 [3];
  logic signed [61:0] q2 [3];

  always_comb begin
    logic [92:0]        full;
    logic [92:0]        t2;
    logic signed [56:0] q0, q1;
    logic signed [61:0] q2m;
    for (int r = 0; r < 3; r++) begin
      q0   = $signed({3'b000, 54'(p0[r] >> FRAC_BITS)});
      q1   = $signed({4'b0000, 53'(p1[r] >> FRAC_BITS)});
      full = {ph[r], 32'b0} + 93'(pl[r]);
      t2   = full >> FRAC_BITS;
      q2m  = $signed({1'b0, 61'((t2 > SAT93) ? SAT93 : t2)});
      sum01_c[r] = (s0[r] ? -q0 : q0) + (s1[r] ? -q1 : q1);
      q2_c[r]    = s2[r] ? -q2m : q2m;
    end
  end

  // C3, C4: saturating sums
  logic signed [61:0] s3 [3];
  logic signed [61:0] uvw [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sum01[r] <= sum01_c[r];
        q2[r]    <= q2_c[r];
        s3[r]    <= clamp_s(63'(sum01[r]) + 63'(q2[r]));
        uvw[r]   <= clamp_s(63'(s3[r]) + 63'($signed(mat[r][3])));
      end
    end
  end

  // Dividers
  logic [60:0] au, av, aw, dw;
  logic        wfail;

  assign au    = 61'(uvw[0][61] ? -uvw[0] : uvw[0]);
  assign av    = 61'(uvw[1][61] ? -uvw[1] : uvw[1]);
  assign aw    = 61'(uvw[2][61] ? -uvw[2] : uvw[2]);
  assign wfail = aw <= 61'(W_EPS);
  assign dw    = wfail ? 61'd1 : aw;

  logic [16:0] qu, qv;
  logic [60:0] ru, rv;
  logic        ou, ov;
  logic [1:0]  su;
  logic [0:0]  sv;
  logic [60:0] du;

  grc_div_pipe #(.NW(61), .DW(61), .QB(17), .SW(2)) u_div_u (
    .clk    (clk),
    .en     (en),
    .num    (au),
    .den    (dw),
    .side   ({wfail, uvw[0][61] ^ uvw[2][61]}),
    .quo    (qu),
    .rem    (ru),
    .over   (ou),
    .side_q (su)
  );

  grc_div_pipe #(.NW(61), .DW(61), .QB(17), .SW(1)) u_div_v (
    .clk    (clk),
    .en     (en),
    .num    (av),
    .den    (dw),
    .side   (uvw[1][61] ^ uvw[2][61]),
    .quo    (qv),
    .rem    (rv),
    .over   (ov),
    .side_q (sv)
  );

  // divisor carried in a delay line beside the dividers, lined up with their outputs
  logic [60:0] dw_st [18];

  always_ff @(posedge clk) begin
    if (en) begin
      dw_st[0] <= dw;
      for (int k = 1; k < 18; k++) dw_st[k] <= dw_st[k-1];
    end
  end

  assign du = dw_st[17];

  // C6: rounding
  always_ff @(posedge clk) begin
    if (en) begin
      fail <= su[1];
      px   <= su[1] ? FAIL_PIX : round_pix(qu, ru, du, ou, su[0]);
      py   <= su[1] ? FAIL_PIX : round_pix(qv, rv, du, ov, sv[0]);
    end
  end

endmodule

FILE: hw/rtl/ground_region_corners_from_rows.sv
// ----------------------------------------------------------------------------
// ground_region_corners_from_rows
// Ground trapezoid corners from a far row, a near row and two ground widths.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel carrying row_top, row_bottom, width_top and
//            width_bottom. One transaction in is one transaction out on result.
//   result : valid/ready channel with four pixel corners and a status code.
//   cfg    : write port for the projection matrix, camera height and frame
//            rows; write only while no transaction is in flight.
// Timing:
//   One transaction per cycle sustained while results are taken. Each one passes
//   through the depth lanes (3 arithmetic stages and a 61-stage quotient
//   pipeline), the corner lanes (4 projection stages, an 18-stage divider, a
//   rounding stage), and the output register.
//   Two depth lanes solve the far and near rows; four corner lanes project the
//   corners; a merge stage forms the status and masks the corners.
// Reset clears the pipeline valid bits and loads the default registers.
// When the receiver stalls with a result held, the whole pipeline holds and
// item.ready drops; it returns the cycle the result is taken.
// ----------------------------------------------------------------------------
module ground_region_corners_from_rows
  import grc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  grc_item_if.sink     item,
  grc_result_if.source result
);

  localparam int LAT = DEPTH_LAT + CORNER_LAT;

  // Configuration registers
  logic [63:0] row0_a, row0_b, row1_a, row1_b, row2_a, row2_b;
  logic [20:0] cam_h;
  logic [11:0] frame_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0_a     <= 64'd65536;
      row0_b     <= '0;
      row1_a     <= '0;
      row1_b     <= '0;
      row2_a     <= '0;
      row2_b     <= '0;
      cam_h      <= 21'd131072;
      frame_rows <= 12'd1080;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0_A:   row0_a     <= cfg_data;
        REG_ROW0_B:   row0_b     <= cfg_data;
        REG_ROW1_A:   row1_a     <= cfg_data;
        REG_ROW1_B:   row1_b     <= cfg_data;
        REG_ROW2_A:   row2_a     <= cfg_data;
        REG_ROW2_B:   row2_b     <= cfg_data;
        REG_CAM_H:    cam_h      <= cfg_data[20:0];
        REG_FRAME_RS: frame_rows <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  mat_t mat;
  assign mat[0] = {row0_b[63:32], row0_b[31:0], row0_a[63:32], row0_a[31:0]};
  assign mat[1] = {row1_b[63:32], row1_b[31:0], row1_a[63:32], row1_a[31:0]};
  assign mat[2] = {row2_b[63:32], row2_b[31:0], row2_a[63:32], row2_a[31:0]};

  // Pipeline control
  logic           en;
  logic           out_valid;
  logic [LAT-1:0] vp;

  assign en         = !out_valid || result.ready;
  assign item.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vp        <= {vp[LAT-2:0], item.valid};
      out_valid <= vp[LAT-1];
    end
  end

  // Side data delay lines
  typedef struct packed {
    logic        rows_bad;
    logic [21:0] hwt;
    logic [21:0] hwb;
  } side1_t;

  typedef struct packed {
    logic rows_bad;
    logic den_bad;
  } side2_t;

  side1_t side1_in;
  side1_t d1 [DEPTH_LAT];
  side2_t d2 [CORNER_LAT];
  depth_t dep [2];

  assign side1_in.rows_bad = !((item.row_top < item.row_bottom) &&
                               (item.row_bottom < frame_rows));
  assign side1_in.hwt      = item.width_top[22:1];
  assign side1_in.hwb      = item.width_bottom[22:1];

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= side1_in;
      for (int k = 1; k < DEPTH_LAT; k++) d1[k] <= d1[k-1];
      d2[0] <= '{rows_bad: d1[DEPTH_LAT-1].rows_bad, den_bad: dep[0].bad || dep[1].bad};
      for (int k = 1; k < CORNER_LAT; k++) d2[k] <= d2[k-1];
    end
  end

  // Depth lanes: far row, near row
  logic [11:0] lane_row [2];
  assign lane_row[0] = item.row_top;
  assign lane_row[1] = item.row_bottom;

  for (genvar i = 0; i < 2; i++) begin : g_depth
    grc_depth_lane #(.FRAC_BITS(FRAC_BITS)) u_depth (
      .clk (clk),
      .en  (en),
      .row (lane_row[i]),
      .mat (mat),
      .h   (cam_h),
      .dep (dep[i])
    );
  end

  // Corner lanes: bottom left, bottom right, top right, top left
  logic signed [15:0] px [4];
  logic signed [15:0] py [4];
  logic [3:0]         cfail;

  for (genvar c = 0; c < 4; c++) begin : g_corner
    grc_corner_lane #(.FRAC_BITS(FRAC_BITS)) u_corner (
      .clk  (clk),
      .en   (en),
      .mat  (mat),
      .h    (cam_h),
      .hw   ((c < 2) ? d1[DEPTH_LAT-1].hwb : d1[DEPTH_LAT-1].hwt),
      .xneg ((c == 0) || (c == 3)),
      .dep  ((c < 2) ? dep[1] : dep[0]),
      .px   (px[c]),
      .py   (py[c]),
      .fail (cfail[c])
    );
  end

  // Merge
  side2_t             sd;
  status_t            st_next;
  logic               zero_pix;
  logic signed [15:0] pix_next [8];
  logic signed [15:0] pix [8];
  status_t            st;

  assign sd = d2[CORNER_LAT-1];

  always_comb begin
    zero_pix = 1'b1;
    if (sd.rows_bad) begin
      st_next = ST_ROWS_BAD;
    end else if (sd.den_bad) begin
      st_next = ST_DEPTH_BAD;
    end else if (|cfail) begin
      st_next  = ST_PROJ_FAIL;
      zero_pix = 1'b0;
    end else begin
      st_next  = ST_OK;
      zero_pix = 1'b0;
    end
    for (int c = 0; c < 4; c++) begin
      pix_next[2*c]   = zero_pix ? 16'sd0 : px[c];
      pix_next[2*c+1] = zero_pix ? 16'sd0 : py[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix <= pix_next;
      st  <= st_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.bottom_left_x  = pix[0];
  assign result.bottom_left_y  = pix[1];
  assign result.bottom_right_x = pix[2];
  assign result.bottom_right_y = pix[3];
  assign result.top_right_x    = pix[4];
  assign result.top_right_y    = pix[5];
  assign result.top_left_x     = pix[6];
  assign result.top_left_y     = pix[7];
  assign result.status         = st;

  // Assertions
  a_rows_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == ST_ROWS_BAD) |->
      (result.bottom_left_x == 0 && result.bottom_left_y == 0 &&
       result.top_right_x == 0 && result.top_left_y == 0))
    else $error("rows invalid result carries nonzero corners");

  a_depth_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == ST_DEPTH_BAD) |->
      (result.bottom_right_x == 0 && result.bottom_right_y == 0 &&
       result.top_left_x == 0 && result.top_right_y == 0))
    else $error("depth failure result carries nonzero corners");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (en && !vp[LAT-1]) |=> !result.valid)
    else $error("result shown without a transaction at the pipeline end");

endmodule
